/* rtl/blsq_pkg.sv */
package blsq_pkg;

    localparam int unsigned SOC_W     = 7;
    localparam int unsigned MV_W      = 13;
    localparam int unsigned MV_EXT_W  = MV_W + 1;
    localparam int unsigned CUR_W     = 25;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DW    = MV_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELAY_CUTOFF = 3'd0,
        REG_SOFT_CUTOFF  = 3'd1,
        REG_PACK_LOW_EN  = 3'd2,
        REG_PACK_DOUBLED = 3'd3,
        REG_EVENT_EN     = 3'd4
    } cfg_index_t;

    localparam logic [MV_W-1:0]        DELAY_CUTOFF_RESET = 13'd3050;
    localparam logic [MV_W-1:0]        SOFT_CUTOFF_RESET  = 13'd2900;
    localparam logic [MV_EXT_W-1:0]    HEAVY_MARGIN_MV    = 14'd50;
    localparam logic [MV_EXT_W-1:0]    PACK_MARGIN_MV     = 14'd100;
    localparam logic signed [CUR_W-1:0] HEAVY_CURRENT_UA  = 25'sd2000000;
    localparam logic [3:0]             PACK_LOW_SAMPLES   = 4'd10;
    localparam logic [1:0]             HEAVY_COUNT_MAX    = 2'd3;
    localparam logic [SOC_W-1:0]       SOC_LOW_ZONE       = 7'd1;

    typedef struct packed {
        logic [MV_W-1:0] delay_cutoff_mv;
        logic [MV_W-1:0] soft_cutoff_mv;
        logic            pack_low_enable;
        logic            pack_doubled;
        logic            event_enable;
    } cfg_t;

    typedef struct packed {
        logic [SOC_W-1:0]        soc_in;
        logic [MV_W-1:0]         mean_voltage_mv;
        logic signed [CUR_W-1:0] battery_current_ua;
        logic [MV_W-1:0]         pack_voltage_mv;
        logic                    is_charging;
        logic                    gauge_ok;
    } sample_t;

    typedef struct packed {
        logic [SOC_W-1:0] soc_out;
        logic             shutdown_delay;
        logic             delay_cancelled;
        logic             change_event;
    } result_t;

endpackage

/* rtl/battery_low_shutdown_qualifier.sv */
// Takes one battery sample word per cycle when the output side is not stalled and
// returns one result word for each: the sample is captured in an input register,
// evaluated against the counters and flags in a single pass, and the result is held
// in an output register until the receiver takes it. A new sample can be accepted while
// the previous one moves into the output register. Configuration writes take effect on
// the next cycle and must only be made while the block is idle.
module battery_low_shutdown_qualifier (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [blsq_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [blsq_pkg::CFG_DW-1:0]            cfg_wdata,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [blsq_pkg::SOC_W-1:0]             s_soc_in,
    input  logic [blsq_pkg::MV_W-1:0]              s_mean_voltage_mv,
    input  logic signed [blsq_pkg::CUR_W-1:0]      s_battery_current_ua,
    input  logic [blsq_pkg::MV_W-1:0]              s_pack_voltage_mv,
    input  logic                                   s_is_charging,
    input  logic                                   s_gauge_ok,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [blsq_pkg::SOC_W-1:0]             m_soc_out,
    output logic                                   m_shutdown_delay,
    output logic                                   m_delay_cancelled,
    output logic                                   m_change_event
);

    blsq_pkg::cfg_t    cfg;
    blsq_pkg::sample_t in_reg;
    blsq_pkg::result_t res;
    blsq_pkg::result_t out_reg;
    logic              in_valid_reg;
    logic              out_valid_reg;
    logic              step;

    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;

    blsq_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    blsq_qualify u_qualify (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .cfg     (cfg),
        .sample  (in_reg),
        .result  (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (step) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg.soc_in             <= s_soc_in;
            in_reg.mean_voltage_mv    <= s_mean_voltage_mv;
            in_reg.battery_current_ua <= s_battery_current_ua;
            in_reg.pack_voltage_mv    <= s_pack_voltage_mv;
            in_reg.is_charging        <= s_is_charging;
            in_reg.gauge_ok           <= s_gauge_ok;
        end
        if (step) begin
            out_reg <= res;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_soc_out         = out_reg.soc_out;
    assign m_shutdown_delay  = out_reg.shutdown_delay;
    assign m_delay_cancelled = out_reg.delay_cancelled;
    assign m_change_event    = out_reg.change_event;

endmodule

/* rtl/blsq_cfg_regs.sv */
module blsq_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [blsq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [blsq_pkg::CFG_DW-1:0]      cfg_wdata,
    output blsq_pkg::cfg_t                   cfg
);

    blsq_pkg::cfg_t cfg_reg;
    blsq_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                blsq_pkg::REG_DELAY_CUTOFF: cfg_next.delay_cutoff_mv = cfg_wdata;
                blsq_pkg::REG_SOFT_CUTOFF:  cfg_next.soft_cutoff_mv  = cfg_wdata;
                blsq_pkg::REG_PACK_LOW_EN:  cfg_next.pack_low_enable = cfg_wdata[0];
                blsq_pkg::REG_PACK_DOUBLED: cfg_next.pack_doubled    = cfg_wdata[0];
                blsq_pkg::REG_EVENT_EN:     cfg_next.event_enable    = cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.delay_cutoff_mv <= blsq_pkg::DELAY_CUTOFF_RESET;
            cfg_reg.soft_cutoff_mv  <= blsq_pkg::SOFT_CUTOFF_RESET;
            cfg_reg.pack_low_enable <= 1'b0;
            cfg_reg.pack_doubled    <= 1'b0;
            cfg_reg.event_enable    <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/blsq_qualify.sv */
module blsq_qualify (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  blsq_pkg::cfg_t    cfg,
    input  blsq_pkg::sample_t sample,
    output blsq_pkg::result_t result
);

    logic [3:0] pack_low_count_reg;
    logic [3:0] pack_low_count_next;
    logic [1:0] load_run_count_reg;
    logic [1:0] load_run_count_next;
    logic       delay_flag_reg;
    logic       delay_flag_next;
    logic       cancel_flag_reg;
    logic       cancel_flag_next;
    logic       reported_flag_reg;
    logic       reported_flag_next;

    logic [blsq_pkg::MV_EXT_W-1:0] pack_mv;
    logic [blsq_pkg::MV_EXT_W-1:0] pack_limit_mv;
    logic [blsq_pkg::MV_EXT_W-1:0] heavy_limit_mv;
    logic                          pack_low;
    logic                          fire;
    logic                          low_zone;
    logic                          heavy_cond;
    logic                          heavy;
    logic                          low_mean;
    logic                          chg;
    logic                          event_hit;

    always_comb begin
        chg            = sample.is_charging;
        pack_mv        = cfg.pack_doubled ? {sample.pack_voltage_mv, 1'b0}
                                          : {1'b0, sample.pack_voltage_mv};
        pack_limit_mv  = {1'b0, cfg.soft_cutoff_mv} + blsq_pkg::PACK_MARGIN_MV;
        heavy_limit_mv = {1'b0, cfg.delay_cutoff_mv} + blsq_pkg::HEAVY_MARGIN_MV;
        pack_low       = !sample.gauge_ok && (pack_low_count_reg < blsq_pkg::PACK_LOW_SAMPLES)
                         && (pack_mv <= pack_limit_mv);

        if (cfg.pack_low_enable) begin
            pack_low_count_next = pack_low ? pack_low_count_reg + 4'd1 : 4'd0;
        end else begin
            pack_low_count_next = pack_low_count_reg;
        end
        fire = cfg.pack_low_enable && (pack_low_count_next >= blsq_pkg::PACK_LOW_SAMPLES);

        low_zone   = sample.soc_in <= blsq_pkg::SOC_LOW_ZONE;
        heavy_cond = ({1'b0, sample.mean_voltage_mv} < heavy_limit_mv)
                     && (sample.battery_current_ua > blsq_pkg::HEAVY_CURRENT_UA);
        low_mean   = sample.mean_voltage_mv <= cfg.delay_cutoff_mv;

        load_run_count_next = load_run_count_reg;
        delay_flag_next     = delay_flag_reg;
        cancel_flag_next    = cancel_flag_reg;
        result.soc_out      = sample.soc_in;
        heavy               = 1'b0;

        if (fire && !chg) begin
            delay_flag_next  = 1'b1;
            cancel_flag_next = 1'b0;
            result.soc_out   = blsq_pkg::SOC_LOW_ZONE;
        end else if (low_zone) begin
            if (heavy_cond) begin
                if (load_run_count_reg < blsq_pkg::HEAVY_COUNT_MAX) begin
                    load_run_count_next = load_run_count_reg + 2'd1;
                end
            end else begin
                load_run_count_next = 2'd0;
            end
            heavy = load_run_count_next == blsq_pkg::HEAVY_COUNT_MAX;
            if ((low_mean || heavy) && !chg) begin
                delay_flag_next  = 1'b1;
                cancel_flag_next = 1'b0;
            end else if (chg) begin
                if (delay_flag_reg) begin
                    delay_flag_next  = 1'b0;
                    cancel_flag_next = 1'b1;
                end
            end else begin
                delay_flag_next = 1'b0;
            end
            result.soc_out = blsq_pkg::SOC_LOW_ZONE;
        end else begin
            delay_flag_next  = 1'b0;
            cancel_flag_next = 1'b0;
        end

        event_hit          = (reported_flag_reg != delay_flag_next) && cfg.event_enable;
        reported_flag_next = event_hit ? delay_flag_next : reported_flag_reg;

        result.shutdown_delay  = delay_flag_next;
        result.delay_cancelled = cancel_flag_next;
        result.change_event    = event_hit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pack_low_count_reg <= 4'd0;
            load_run_count_reg <= 2'd0;
            delay_flag_reg     <= 1'b0;
            cancel_flag_reg    <= 1'b0;
            reported_flag_reg  <= 1'b0;
        end else if (step) begin
            pack_low_count_reg <= pack_low_count_next;
            load_run_count_reg <= load_run_count_next;
            delay_flag_reg     <= delay_flag_next;
            cancel_flag_reg    <= cancel_flag_next;
            reported_flag_reg  <= reported_flag_next;
        end
    end

    a_pack_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pack_low_count_reg <= blsq_pkg::PACK_LOW_SAMPLES)
        else $error("pack-low count out of range");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(delay_flag_reg && cancel_flag_reg))
        else $error("delay and cancel flags both set");

    a_charging_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step && sample.is_charging |=> !delay_flag_reg)
        else $error("delay flag set after a charging sample");

    a_pack_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !cfg.pack_low_enable |=> $stable(pack_low_count_reg))
        else $error("pack-low count moved while disabled");

endmodule

/* tb/tb_battery_low_shutdown_qualifier.sv */
module tb_battery_low_shutdown_qualifier;
    timeunit 1ns;
    timeprecision 1ps;

    import blsq_pkg::*;

    localparam int HEAVY_CURRENT_LIMIT = 2000000;
    localparam int HEAVY_MARGIN        = 50;
    localparam int PACK_MARGIN         = 100;
    localparam int PACK_LOW_RUN        = 10;
    localparam int STALL_LIMIT         = 2000;
    localparam int HOLD_OFF_CYCLES     = 80;
    localparam int DRAIN_CYCLES        = 4;
    localparam int MAX_PRINTED         = 100;

    typedef enum {SEQ_NOISE, SEQ_LOW_ZONE, SEQ_PACK_LOW} seq_kind_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DW-1:0]       cfg_wdata = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [SOC_W-1:0]        s_soc_in = '0;
    logic [MV_W-1:0]         s_mean_voltage_mv = '0;
    logic signed [CUR_W-1:0] s_battery_current_ua = '0;
    logic [MV_W-1:0]         s_pack_voltage_mv = '0;
    logic                    s_is_charging = 1'b0;
    logic                    s_gauge_ok = 1'b0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [SOC_W-1:0]        m_soc_out;
    logic                    m_shutdown_delay;
    logic                    m_delay_cancelled;
    logic                    m_change_event;

    cfg_t       shadow_cfg;
    logic [1:0] load_run_count;
    logic [3:0] pack_low_count;
    logic       delay_flag;
    logic       cancel_flag;
    logic       reported_flag;

    result_t pending_results[$];
    int      mismatch_count = 0;
    int      burst_left = 0;
    bit      sender_gaps_on = 1'b1;
    bit      hold_off_request = 1'b0;
    int      stalled_cycles = 0;

    battery_low_shutdown_qualifier i_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_soc_in            (s_soc_in),
        .s_mean_voltage_mv   (s_mean_voltage_mv),
        .s_battery_current_ua(s_battery_current_ua),
        .s_pack_voltage_mv   (s_pack_voltage_mv),
        .s_is_charging       (s_is_charging),
        .s_gauge_ok          (s_gauge_ok),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_soc_out           (m_soc_out),
        .m_shutdown_delay    (m_shutdown_delay),
        .m_delay_cancelled   (m_delay_cancelled),
        .m_change_event      (m_change_event)
    );

    always #5 aclk = ~aclk;

    function automatic result_t qualify_sample(sample_t smp);
        result_t res;
        int      pack_mv;
        logic    fire;
        logic    heavy;
        res.soc_out = smp.soc_in;
        res.change_event = 1'b0;
        fire = 1'b0;
        if (shadow_cfg.pack_low_enable) begin
            pack_mv = int'(smp.pack_voltage_mv);
            if (shadow_cfg.pack_doubled) begin
                pack_mv = 2 * pack_mv;
            end
            if (!smp.gauge_ok && pack_low_count < PACK_LOW_RUN
                    && pack_mv <= int'(shadow_cfg.soft_cutoff_mv) + PACK_MARGIN) begin
                pack_low_count++;
            end else begin
                pack_low_count = '0;
            end
            fire = (pack_low_count >= PACK_LOW_RUN);
        end
        if (fire && !smp.is_charging) begin
            delay_flag = 1'b1;
            cancel_flag = 1'b0;
            res.soc_out = SOC_W'(1);
        end else if (smp.soc_in <= 1) begin
            if (int'(smp.mean_voltage_mv) < int'(shadow_cfg.delay_cutoff_mv) + HEAVY_MARGIN
                    && int'(smp.battery_current_ua) > HEAVY_CURRENT_LIMIT) begin
                if (load_run_count < 3) begin
                    load_run_count++;
                end
            end else begin
                load_run_count = '0;
            end
            heavy = (load_run_count > 2);
            if ((smp.mean_voltage_mv <= shadow_cfg.delay_cutoff_mv || heavy)
                    && !smp.is_charging) begin
                delay_flag = 1'b1;
                cancel_flag = 1'b0;
            end else if (smp.is_charging) begin
                if (delay_flag) begin
                    delay_flag = 1'b0;
                    cancel_flag = 1'b1;
                end
            end else begin
                delay_flag = 1'b0;
            end
            res.soc_out = SOC_W'(1);
        end else begin
            delay_flag = 1'b0;
            cancel_flag = 1'b0;
        end
        if (reported_flag != delay_flag && shadow_cfg.event_enable) begin
            res.change_event = 1'b1;
            reported_flag = delay_flag;
        end
        res.shutdown_delay = delay_flag;
        res.delay_cancelled = cancel_flag;
        return res;
    endfunction

    function automatic sample_t make_sample(int soc, int mean_mv, int cur_ua, int pack_mv,
                                            bit charging, bit gauge);
        sample_t smp;
        smp.soc_in = SOC_W'(soc);
        smp.mean_voltage_mv = MV_W'(mean_mv);
        smp.battery_current_ua = CUR_W'(cur_ua);
        smp.pack_voltage_mv = MV_W'(pack_mv);
        smp.is_charging = charging;
        smp.gauge_ok = gauge;
        return smp;
    endfunction

    function automatic int clamp_mv(int mv);
        if (mv < 0) begin
            return 0;
        end
        if (mv > 8191) begin
            return 8191;
        end
        return mv;
    endfunction

    function automatic sample_t random_sample(seq_kind_t kind);
        sample_t smp;
        int      offs;
        int      target;
        int      pick;
        smp = make_sample($urandom_range(0, 127), $urandom, $urandom, $urandom,
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        case (kind)
            SEQ_LOW_ZONE: begin
                if ($urandom_range(0, 9) != 0) begin
                    smp.soc_in = SOC_W'($urandom_range(0, 1));
                end
                offs = $urandom_range(0, 140);
                smp.mean_voltage_mv =
                    MV_W'(clamp_mv(int'(shadow_cfg.delay_cutoff_mv) + offs - 70));
                pick = $urandom_range(0, 9);
                if (pick < 6) begin
                    smp.battery_current_ua = CUR_W'($urandom_range(HEAVY_CURRENT_LIMIT + 1,
                                                                   16777215));
                end else if (pick == 6) begin
                    smp.battery_current_ua = CUR_W'(HEAVY_CURRENT_LIMIT + $urandom_range(0, 1));
                end
                smp.is_charging = ($urandom_range(0, 7) == 0);
            end
            SEQ_PACK_LOW: begin
                if ($urandom_range(0, 1) == 0) begin
                    smp.soc_in = SOC_W'($urandom_range(0, 1));
                end
                target = int'(shadow_cfg.soft_cutoff_mv) + PACK_MARGIN;
                if (shadow_cfg.pack_doubled) begin
                    target = target / 2;
                end
                if ($urandom_range(0, 9) == 0) begin
                    offs = $urandom_range(1, 50);
                    smp.pack_voltage_mv = MV_W'(clamp_mv(target + offs));
                end else begin
                    offs = $urandom_range(0, 150);
                    smp.pack_voltage_mv = MV_W'(clamp_mv(target - offs));
                end
                smp.gauge_ok = ($urandom_range(0, 11) == 0);
                smp.is_charging = ($urandom_range(0, 7) == 0);
            end
            default: begin
            end
        endcase
        return smp;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) begin
            $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    task automatic send_sample(sample_t smp);
        int gap;
        if (burst_left == 0) begin
            gap = sender_gaps_on ? $urandom_range(0, 8) : 0;
            repeat (gap) begin
                @(negedge aclk);
                s_valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_soc_in <= smp.soc_in;
        s_mean_voltage_mv <= smp.mean_voltage_mv;
        s_battery_current_ua <= smp.battery_current_ua;
        s_pack_voltage_mv <= smp.pack_voltage_mv;
        s_is_charging <= smp.is_charging;
        s_gauge_ok <= smp.gauge_ok;
        do @(posedge aclk); while (s_ready !== 1'b1);
        pending_results.push_back(qualify_sample(smp));
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_register(cfg_index_t idx, int value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DW'(value);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_DELAY_CUTOFF: shadow_cfg.delay_cutoff_mv = MV_W'(value);
            REG_SOFT_CUTOFF:  shadow_cfg.soft_cutoff_mv = MV_W'(value);
            REG_PACK_LOW_EN:  shadow_cfg.pack_low_enable = value[0];
            REG_PACK_DOUBLED: shadow_cfg.pack_doubled = value[0];
            REG_EVENT_EN:     shadow_cfg.event_enable = value[0];
            default: begin
            end
        endcase
    endtask

    task automatic apply_settings(int delay_mv, int soft_mv, bit pack_en, bit doubled,
                                  bit evt_en);
        write_register(REG_DELAY_CUTOFF, delay_mv);
        write_register(REG_SOFT_CUTOFF, soft_mv);
        write_register(REG_PACK_LOW_EN, pack_en);
        write_register(REG_PACK_DOUBLED, doubled);
        write_register(REG_EVENT_EN, evt_en);
        repeat (2) @(negedge aclk);
    endtask

    task automatic run_random_sequences(int count);
        int        sent;
        int        run_len;
        int        pick;
        seq_kind_t kind;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 9);
            kind = (pick < 3) ? SEQ_NOISE : (pick < 7) ? SEQ_LOW_ZONE : SEQ_PACK_LOW;
            run_len = (kind == SEQ_PACK_LOW) ? $urandom_range(8, 14) : $urandom_range(3, 20);
            repeat (run_len) begin
                send_sample(random_sample(kind));
                sent++;
            end
        end
    endtask

    task automatic reset_dut();
        shadow_cfg.delay_cutoff_mv = DELAY_CUTOFF_RESET;
        shadow_cfg.soft_cutoff_mv = SOFT_CUTOFF_RESET;
        shadow_cfg.pack_low_enable = 1'b0;
        shadow_cfg.pack_doubled = 1'b0;
        shadow_cfg.event_enable = 1'b1;
        load_run_count = '0;
        pack_low_count = '0;
        delay_flag = 1'b0;
        cancel_flag = 1'b0;
        reported_flag = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);
    endtask

    task automatic test_low_zone_directed();
        send_sample(make_sample(100, 8191, 16777215, 8191, 1'b0, 1'b1));
        send_sample(make_sample(127, 0, -16777216, 0, 1'b1, 1'b0));
        send_sample(make_sample(101, 3000, 0, 4000, 1'b0, 1'b1));
        send_sample(make_sample(1, 3050, 0, 4000, 1'b0, 1'b1));
        send_sample(make_sample(0, 3051, HEAVY_CURRENT_LIMIT, 4000, 1'b0, 1'b1));
        repeat (4) begin
            send_sample(make_sample(0, 3099, HEAVY_CURRENT_LIMIT + 1, 4000, 1'b0, 1'b1));
        end
        send_sample(make_sample(0, 3099, HEAVY_CURRENT_LIMIT + 1, 4000, 1'b1, 1'b1));
        send_sample(make_sample(1, 3500, 0, 4000, 1'b1, 1'b1));
        send_sample(make_sample(2, 3500, 0, 4000, 1'b0, 1'b1));
        send_sample(make_sample(0, 0, -16777216, 4000, 1'b0, 1'b1));
        send_sample(make_sample(0, 3100, HEAVY_CURRENT_LIMIT + 1, 4000, 1'b0, 1'b1));
        drain_results();
    endtask

    task automatic test_pack_low_directed();
        apply_settings(2500, 2500, 1'b1, 1'b1, 1'b1);
        repeat (PACK_LOW_RUN) begin
            send_sample(make_sample(50, 4000, 0, 1300, 1'b0, 1'b0));
        end
        send_sample(make_sample(80, 4000, 0, 1300, 1'b0, 1'b0));
        send_sample(make_sample(60, 4000, 0, 1301, 1'b0, 1'b0));
        send_sample(make_sample(60, 4000, 0, 8191, 1'b0, 1'b0));
        send_sample(make_sample(60, 4000, 0, 0, 1'b0, 1'b1));
        drain_results();
    endtask

    task automatic test_random_low_limits();
        apply_settings(2500, 2500, 1'b1, 1'b1, 1'b1);
        run_random_sequences(250);
        drain_results();
    endtask

    task automatic test_random_high_limits();
        apply_settings(4500, 4500, 1'b1, 1'b0, 1'b0);
        run_random_sequences(250);
        drain_results();
    endtask

    task automatic test_random_mixed_settings();
        repeat (5) begin
            apply_settings($urandom_range(2500, 4500), $urandom_range(2500, 4500),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
            run_random_sequences(50);
            drain_results();
        end
    endtask

    task automatic test_full_backpressure();
        apply_settings(3050, 2900, 1'b1, 1'b0, 1'b1);
        sender_gaps_on = 1'b0;
        burst_left = 0;
        hold_off_request = 1'b1;
        run_random_sequences(40);
        sender_gaps_on = 1'b1;
        drain_results();
    endtask

    task automatic test_sender_pause();
        apply_settings(DELAY_CUTOFF_RESET, SOFT_CUTOFF_RESET, 1'b0, 1'b0, 1'b1);
        run_random_sequences(20);
        drain_results();
        run_random_sequences(20);
        drain_results();
    endtask

    initial begin
        reset_dut();
        test_low_zone_directed();
        test_pack_low_directed();
        test_random_low_limits();
        test_random_high_limits();
        test_random_mixed_settings();
        test_full_backpressure();
        test_sender_pause();
        drain_results();
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // The receiver alternates between stall modes, and holds off for a long
    // stretch on request so that the block fills up and refuses new words.
    initial begin
        int hold_left;
        int mode;
        int mode_left;
        int phase;
        hold_left = 0;
        mode = 0;
        mode_left = 0;
        phase = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(10, 60);
            end
            mode_left--;
            phase++;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ((phase % 4) < 2);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result word with nothing expected", m_soc_out, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_soc_out !== want.soc_out) begin
                    report_mismatch("soc_out", m_soc_out, want.soc_out);
                end
                if (m_shutdown_delay !== want.shutdown_delay) begin
                    report_mismatch("shutdown_delay", m_shutdown_delay, want.shutdown_delay);
                end
                if (m_delay_cancelled !== want.delay_cancelled) begin
                    report_mismatch("delay_cancelled", m_delay_cancelled,
                                    want.delay_cancelled);
                end
                if (m_change_event !== want.change_event) begin
                    report_mismatch("change_event", m_change_event, want.change_event);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready)) begin
            stalled_cycles = 0;
        end else begin
            stalled_cycles++;
        end
        if (stalled_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule

/* sim.f */
rtl/blsq_pkg.sv
rtl/blsq_cfg_regs.sv
rtl/blsq_qualify.sv
rtl/battery_low_shutdown_qualifier.sv
tb/tb_battery_low_shutdown_qualifier.sv
